@@ hw/rtl/sfb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfb_pkg - shared types and constants of the sensor frame builder
// Frame constants, the command passed from classifier to serializer,
// and the CRC-8/MAXIM byte update.
// ---------------------------------------------------------------------------
package sfb_pkg;

    localparam int unsigned CNT_W        = 3;
    localparam logic [CNT_W-1:0] MAX_READINGS = 3'd6;

    localparam logic [7:0] MSG_TYPE_SENSOR = 8'h01;
    localparam logic [7:0] CRC_POLY_REFL   = 8'h8C;
    localparam logic [7:0] CRC_INIT        = 8'h00;
    localparam logic [7:0] NODE_ID_RESET   = 8'h01;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned PADDR_W    = 3;
    localparam logic        REG_NODE_ID = 1'b0;

    typedef struct packed {
        logic             open;
        logic             close;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       stype;
        logic [15:0]      value;
    } t_cmd;

    // reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sfb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfb_front - reading classifier
// Tracks the open frame and turns each reading into a serializer command.
// ---------------------------------------------------------------------------
module sfb_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [7:0]              i_stype,
    input  wire logic [15:0]             i_value,
    input  wire logic [sfb_pkg::CNT_W-1:0] i_cnt,
    input  wire logic                    i_q_ready,
    output logic                         o_push,
    output sfb_pkg::t_cmd                o_cmd
);

    logic [sfb_pkg::CNT_W-1:0] r_left;
    logic [sfb_pkg::CNT_W-1:0] n_left;
    logic [sfb_pkg::CNT_W-1:0] cnt_sat;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign cnt_sat = (i_cnt > sfb_pkg::MAX_READINGS) ? sfb_pkg::MAX_READINGS : i_cnt;

    always_comb begin
        o_cmd.stype = i_stype;
        o_cmd.value = i_value;
        o_cmd.cnt   = cnt_sat;
        if (r_left == '0) begin
            o_cmd.open  = 1'b1;
            o_cmd.close = (cnt_sat <= sfb_pkg::CNT_W'(1));
            n_left      = (cnt_sat == '0) ? '0 : cnt_sat - sfb_pkg::CNT_W'(1);
        end else begin
            o_cmd.open  = 1'b0;
            o_cmd.close = (r_left == sfb_pkg::CNT_W'(1));
            n_left      = r_left - sfb_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (o_push) begin
            r_left <= n_left;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/sfb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfb_queue - command queue
// Small FIFO between classifier and serializer.
// ---------------------------------------------------------------------------
module sfb_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  sfb_pkg::t_cmd i_cmd,
    output logic         o_ready,
    input  wire logic    i_pop,
    output logic         o_valid,
    output sfb_pkg::t_cmd o_cmd
);

    sfb_pkg::t_cmd r_mem [sfb_pkg::QUEUE_DEPTH];
    logic [sfb_pkg::QPTR_W-1:0] r_wptr;
    logic [sfb_pkg::QPTR_W-1:0] r_rptr;
    logic [sfb_pkg::QCNT_W-1:0] r_count;

    assign o_ready = (r_count != sfb_pkg::QCNT_W'(sfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + sfb_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + sfb_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + sfb_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - sfb_pkg::QCNT_W'(1);
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready) else $error("push into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sfb_pkg::QCNT_W'(sfb_pkg::QUEUE_DEPTH)) else $error("queue count overflow");

endmodule
`default_nettype wire

@@ hw/rtl/sfb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfb_back - frame serializer
// Emits header, reading and CRC bytes one per cycle through an output register, while i_ready lets it advance.
// ---------------------------------------------------------------------------
module sfb_back (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic [7:0] i_node_id,
    input  wire logic    i_q_valid,
    input  sfb_pkg::t_cmd i_q_cmd,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_ready,
    output logic [7:0]   o_byte,
    output logic         o_eof
);

    typedef enum logic [2:0] {
        S_RELAY,
        S_TYPE,
        S_CNT,
        S_STYPE,
        S_VHI,
        S_VLO,
        S_CRC
    } t_step;

    t_step         r_step;
    t_step         n_step;
    logic          r_busy;
    sfb_pkg::t_cmd r_cmd;
    logic [7:0]    r_crc;
    logic          r_out_valid;
    logic [7:0]    r_byte;
    logic          r_eof;

    logic       adv;
    logic       last;
    logic       load;
    logic [7:0] cur_byte;
    logic [7:0] crc_base;
    logic [7:0] crc_next;

    assign adv  = r_busy && (!r_out_valid || i_ready);
    assign last = (r_step == S_CRC) || ((r_step == S_VLO) && !r_cmd.close);
    assign load = !r_busy || (adv && last);
    assign o_pop = load && i_q_valid;

    always_comb begin
        unique case (r_step)
            S_RELAY: cur_byte = i_node_id;
            S_TYPE:  cur_byte = sfb_pkg::MSG_TYPE_SENSOR;
            S_CNT:   cur_byte = {{(8 - sfb_pkg::CNT_W){1'b0}}, r_cmd.cnt};
            S_STYPE: cur_byte = r_cmd.stype;
            S_VHI:   cur_byte = r_cmd.value[15:8];
            S_VLO:   cur_byte = r_cmd.value[7:0];
            S_CRC:   cur_byte = r_crc;
            default: cur_byte = r_crc;
        endcase
    end

    always_comb begin
        unique case (r_step)
            S_CNT:   n_step = (r_cmd.cnt == '0) ? S_CRC : S_STYPE;
            S_RELAY: n_step = S_TYPE;
            S_TYPE:  n_step = S_CNT;
            S_STYPE: n_step = S_VHI;
            S_VHI:   n_step = S_VLO;
            default: n_step = S_CRC;
        endcase
    end

    assign crc_base = (r_step == S_RELAY) ? sfb_pkg::CRC_INIT : r_crc;
    assign crc_next = sfb_pkg::crc8_feed(crc_base, cur_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= S_RELAY;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_byte      <= cur_byte;
                r_eof       <= (r_step == S_CRC);
                r_crc       <= crc_next;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy <= i_q_valid;
                if (i_q_valid) begin
                    r_cmd  <= i_q_cmd;
                    r_step <= i_q_cmd.open ? S_RELAY : S_STYPE;
                end
            end else if (adv) begin
                r_step <= n_step;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_byte;
    assign o_eof   = r_eof;

    a_crc_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == S_CRC) |-> r_cmd.close) else $error("CRC step without close");
    a_hdr_on_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_cmd.open) |-> (r_step != S_RELAY && r_step != S_TYPE && r_step != S_CNT))
        else $error("header step on non-opening command");
    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid) else $error("advanced step lost its byte");

endmodule
`default_nettype wire

@@ hw/rtl/sensor_frame_builder_crc8.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sensor_frame_builder_crc8 - sensor frame serializer with CRC-8/MAXIM
// Each request is one reading; the frame leaves as one byte per transfer.
// A reading is sent as sensor type and value high and low bytes; the request
// opening a frame first sends node ID, message type and reading count; the one
// closing it adds the CRC (an empty frame is header and CRC). Bytes leave one per
// cycle unless m_axis_tready stalls; a 4-entry queue takes requests as bytes drain.
// ---------------------------------------------------------------------------
module sensor_frame_builder_crc8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] sensor_type, [23:8] reading_value, [26:24] reading_count, [31:27] zero
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [sfb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]    r_node_id;
    logic          push;
    logic          pop;
    logic          q_ready;
    logic          q_valid;
    sfb_pkg::t_cmd f_cmd;
    sfb_pkg::t_cmd q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sfb_pkg::REG_NODE_ID) ? {24'd0, r_node_id} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= sfb_pkg::NODE_ID_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == sfb_pkg::REG_NODE_ID) begin
            r_node_id <= pwdata[7:0];
        end
    end

    sfb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_stype   (s_axis_tdata[7:0]),
        .i_value   (s_axis_tdata[23:8]),
        .i_cnt     (s_axis_tdata[26:24]),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (f_cmd)
    );

    sfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    sfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_node_id  (r_node_id),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_eof      (m_axis_tlast)
    );

    logic unused_pwdata;
    assign unused_pwdata = ^{pwdata[31:8], paddr[1:0], s_axis_tdata[31:27]};

endmodule
`default_nettype wire
